>>> sv/mwc32_pkg.sv
// shared types and constants for the multiply-with-carry generator
`timescale 1ns / 1ps

package mwc32_pkg;

	// stream field widths
	localparam int OP_W    = 2;
	localparam int VAL_W   = 64;
	localparam int HALF_W  = 32;
	localparam int IN_W    = ((OP_W + VAL_W + 7) / 8) * 8;

	// generator and seeding constants
	localparam logic [HALF_W-1:0] MWC_MUL = 32'd4294095429;
	localparam logic [HALF_W-1:0] SEED_K1 = 32'd4110542893;
	localparam logic [HALF_W-1:0] SEED_K2 = 32'd3667735229;
	localparam logic [HALF_W-1:0] SEED_K3 = 32'd4068774709;
	localparam logic [HALF_W-1:0] SEED_K4 = 32'd3322924477;

	localparam int WARMUP_ROUNDS    = 13;
	localparam int RESEED_WORDS     = 10;
	localparam int RESEED_MAX_ITERS = 32;
	localparam int WORD_LO_IDX      = 7;
	localparam int WORD_HI_IDX      = 9;

	localparam int KEPT_W = $clog2(RESEED_WORDS + 1);
	localparam int ITER_W = $clog2(RESEED_MAX_ITERS + 1);
	localparam int WARM_W = (WARMUP_ROUNDS > 0) ? $clog2(WARMUP_ROUNDS + 1) : 1;

	// operation codes
	localparam logic [OP_W-1:0] OP_DRAW   = 2'd0;
	localparam logic [OP_W-1:0] OP_RESEED = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RS_SUM,
		ST_RS_LO,
		ST_RS_HI,
		ST_RS_CHK,
		ST_RS_FORM,
		ST_WARM
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic take;
		logic rs_start;
		logic init;
		logic sum_en;
		logic mul_lo_en;
		logic mul_hi_en;
		logic cap_lo;
		logic cap_hi;
		logic form;
		logic warm_step;
		logic deliver;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic in_reseed;
		logic x_nz;
		logic out_free;
	} dp_sts_t;

endpackage

>>> sv/mwc32_datapath.sv
// datapath: state, seed, lcg and mwc arithmetic, output register
`timescale 1ns / 1ps

module mwc32_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mwc32_pkg::dp_cmd_t       cmd,
	output mwc32_pkg::dp_sts_t       sts,
	input  logic [mwc32_pkg::IN_W-1:0]  s_tdata,
	input  logic                     cfg_valid,
	input  logic [mwc32_pkg::VAL_W-1:0] cfg_data,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [mwc32_pkg::VAL_W-1:0] m_tdata
);
	import mwc32_pkg::*;

	logic [VAL_W-1:0]  state_q;
	logic [VAL_W-1:0]  seed_q;
	logic [OP_W-1:0]   op_q;
	logic [VAL_W-1:0]  load_q;
	logic [VAL_W-1:0]  sum_q;
	logic [VAL_W-1:0]  acc_q;
	logic [VAL_W-1:0]  x_q;
	logic [29:0]       word_lo_q;
	logic [30:0]       word_hi_q;
	logic [VAL_W-1:0]  out_q;
	logic              out_valid_q;
	logic [HALF_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;
	logic [HALF_W-1:0] kmul;
	logic [HALF_W-1:0] kadd;
	logic [VAL_W-1:0]  prod;
	logic [VAL_W-1:0]  mwc_next;
	logic [VAL_W-1:0]  result;
	logic [OP_W-1:0]   in_op;

	assign in_op = s_tdata[OP_W-1:0];

	// lcg constants: first step uses its own pair
	assign kmul = cmd.init ? SEED_K2 : SEED_K3;
	assign kadd = cmd.init ? SEED_K3 : SEED_K4;

	// shared 32x32 multiplier
	always_comb begin
		if (cmd.mul_lo_en) begin
			mul_a = sum_q[HALF_W-1:0];
			mul_b = kmul;
		end else if (cmd.mul_hi_en) begin
			mul_a = sum_q[VAL_W-1:HALF_W];
			mul_b = kmul;
		end else begin
			mul_a = state_q[HALF_W-1:0];
			mul_b = MWC_MUL;
		end
	end

	assign prod     = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
	assign mwc_next = prod + {{HALF_W{1'b0}}, state_q[VAL_W-1:HALF_W]};

	// value committed by the current request
	always_comb begin
		case (op_q)
			OP_DRAW: result = mwc_next;
			OP_LOAD: result = load_q;
			default: result = state_q;
		endcase
	end

	// seed register, always writable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid) begin
			seed_q <= cfg_data;
		end
	end

	// generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cmd.form) begin
			state_q <= {1'b0, word_hi_q, 2'b00, word_lo_q};
		end else if (cmd.warm_step) begin
			state_q <= mwc_next;
		end else if (cmd.deliver) begin
			state_q <= result;
		end
	end

	// request capture and reseed arithmetic
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= in_op;
			load_q <= s_tdata[OP_W+VAL_W-1:OP_W];
		end
		if (cmd.rs_start) begin
			word_lo_q <= '0;
			word_hi_q <= '0;
		end
		if (cmd.sum_en) begin
			sum_q <= seed_q + (cmd.init ? {{HALF_W{1'b0}}, SEED_K1} : x_q);
		end
		if (cmd.mul_lo_en) begin
			acc_q <= prod + {{HALF_W{1'b0}}, kadd};
		end
		if (cmd.mul_hi_en) begin
			x_q <= acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
		end
		if (cmd.cap_lo) begin
			word_lo_q <= x_q[29:0];
		end
		if (cmd.cap_hi) begin
			word_hi_q <= x_q[30:0];
		end
		if (cmd.deliver) begin
			out_q <= result;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.in_reseed = (in_op == OP_RESEED);
	assign sts.x_nz      = (x_q[29:0] != '0);
	assign sts.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

>>> sv/mwc32_ctrl.sv
// controller: request sequencing, reseed word search and warm-up counters
`timescale 1ns / 1ps

module mwc32_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  mwc32_pkg::dp_sts_t  sts,
	output mwc32_pkg::dp_cmd_t  cmd
);
	import mwc32_pkg::*;

	state_t            state_q;
	state_t            state_nx;
	logic              init_q;
	logic [KEPT_W-1:0] kept_q;
	logic [KEPT_W-1:0] kept_nx;
	logic [ITER_W-1:0] iter_q;
	logic [WARM_W-1:0] warm_q;
	logic              take;
	logic              warm_done;

	assign take      = s_tvalid && (state_q == ST_IDLE);
	assign kept_nx   = kept_q + {{(KEPT_W-1){1'b0}}, sts.x_nz};
	assign warm_done = (warm_q == WARM_W'(WARMUP_ROUNDS));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_nx = sts.in_reseed ? ST_RS_SUM : ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			ST_RS_SUM:  state_nx = ST_RS_LO;
			ST_RS_LO:   state_nx = ST_RS_HI;
			ST_RS_HI:   state_nx = init_q ? ST_RS_SUM : ST_RS_CHK;
			ST_RS_CHK: begin
				if (kept_nx < KEPT_W'(RESEED_WORDS) && iter_q < ITER_W'(RESEED_MAX_ITERS)) begin
					state_nx = ST_RS_SUM;
				end else begin
					state_nx = ST_RS_FORM;
				end
			end
			ST_RS_FORM: state_nx = ST_WARM;
			ST_WARM: begin
				if (warm_done) begin
					state_nx = ST_EXEC;
				end
			end
			default:    state_nx = ST_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.take      = take;
		cmd.rs_start  = take && sts.in_reseed;
		cmd.init      = init_q;
		cmd.sum_en    = (state_q == ST_RS_SUM);
		cmd.mul_lo_en = (state_q == ST_RS_LO);
		cmd.mul_hi_en = (state_q == ST_RS_HI);
		cmd.cap_lo    = (state_q == ST_RS_CHK) && sts.x_nz && (kept_q == KEPT_W'(WORD_LO_IDX));
		cmd.cap_hi    = (state_q == ST_RS_CHK) && sts.x_nz && (kept_q == KEPT_W'(WORD_HI_IDX));
		cmd.form      = (state_q == ST_RS_FORM);
		cmd.warm_step = (state_q == ST_WARM) && !warm_done;
		cmd.deliver   = (state_q == ST_EXEC) && sts.out_free;
	end

	assign s_tready = (state_q == ST_IDLE);

	// state register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			init_q  <= 1'b0;
			kept_q  <= '0;
			iter_q  <= '0;
			warm_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (cmd.rs_start) begin
				init_q <= 1'b1;
				kept_q <= '0;
				iter_q <= '0;
			end
			if (state_q == ST_RS_HI) begin
				init_q <= 1'b0;
				if (!init_q) begin
					iter_q <= iter_q + ITER_W'(1);
				end
			end
			if (state_q == ST_RS_CHK) begin
				kept_q <= kept_nx;
			end
			if (cmd.form) begin
				warm_q <= '0;
			end else if (cmd.warm_step) begin
				warm_q <= warm_q + WARM_W'(1);
			end
		end
	end

endmodule

>>> sv/mwc32_generator_with_seeding.sv
// top level of the seeded multiply-with-carry generator
//
// Channels: the slave stream carries one request per beat, s_tdata holding
// the op code in bits 1:0 and a 64-bit load value in bits 65:2. The master
// stream returns one 64-bit state word per request. cfg_valid/cfg_data
// write the 64-bit seed register, always ready; write it only while idle.
// Op 0 steps the generator, op 1 reseeds from the seed register, op 2
// loads the state, op 3 just reports the current state.
// Sequence: a draw, load or report is captured, then its result is
// registered in the output register, a draw through the shared 32x32
// multiplier. A reseed captures the request, runs the first lcg step,
// then 10 to 32 lcg iterations (sum, low and high partial products, word
// check), forms the state, runs the warm-up steps and delivers.
// One request is in flight at a time; the next is taken once the result
// sits in the output register, even while the receiver has not taken it.
// Reset clears the state and seed to zero; draw only after a reseed or
// load. If the receiver stalls, the result holds and the next request
// waits in its final cycle until the output register frees up.
`timescale 1ns / 1ps

module mwc32_generator_with_seeding (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // op [1:0], load_value [65:2], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // value [63:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data   // seed_value [63:0]
);
	import mwc32_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencing
	mwc32_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and storage
	mwc32_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> sv/mwc32_checker.sv
// port-level checks for the generator, bound to the top level
`timescale 1ns / 1ps

module mwc32_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [71:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// result holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// one request in flight
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// a load reports its value once captured and registered at the output, when the output is free
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == 2'd2 && (!m_tvalid || m_tready)
		|=> ##1 (m_tvalid && m_tdata == $past(s_tdata[65:2], 2)))
		else $error("load result mismatch");

endmodule

bind mwc32_generator_with_seeding mwc32_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> test/mwc32_generator_with_seeding_test.sv
// self-checking testbench for the seeded multiply-with-carry generator
`timescale 1ns / 1ps

module mwc32_generator_with_seeding_test;
	import mwc32_pkg::*;

	// op 3 only reports the current state
	localparam logic [OP_W-1:0] OP_REPORT = 2'd3;
	localparam logic [63:0] MASK30 = 64'h0000_0000_3FFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [63:0] cfg_data = '0;

	// idling controls, in percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// predicted generator state, seed register and results still owed
	logic [63:0] gen_state = '0;
	logic [63:0] seed_reg = '0;
	logic [63:0] pending_states[$];

	int n_draw = 0;
	int n_reseed = 0;
	int n_load = 0;
	int n_report = 0;
	int n_seed_writes = 0;
	int n_checked = 0;
	int n_mismatch = 0;
	int n_unexpected = 0;

	mwc32_generator_with_seeding dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // op [1:0], load_value [65:2], zero pad
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // value [63:0]
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)   // seed_value [63:0]
	);

	// clock and one reset at the start
	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	initial begin
		#4_000_000;
		$display("[mwc32_generator_with_seeding] ERROR");
		$finish;
	end

	// one lag-1 step: low half times multiplier plus carry, wrapping
	function automatic logic [63:0] next_mwc(input logic [63:0] s);
		logic [63:0] lo;
		logic [63:0] hi;
		lo = {32'd0, s[31:0]};
		hi = {32'd0, s[63:32]};
		return lo * {32'd0, MWC_MUL} + hi;
	endfunction

	// state built from the seed: lcg word search, then warm-up steps
	function automatic logic [63:0] seeded_mwc(input logic [63:0] seed);
		logic [63:0] x;
		logic [31:0] word_lo;
		logic [31:0] word_hi;
		logic [63:0] s;
		int kept;
		int iter;
		int r;
		x = (seed + {32'd0, SEED_K1}) * {32'd0, SEED_K2} + {32'd0, SEED_K3};
		word_lo = '0;
		word_hi = '0;
		kept = 0;
		iter = 0;
		while (kept < RESEED_WORDS && iter < RESEED_MAX_ITERS) begin
			x = (seed + x) * {32'd0, SEED_K3} + {32'd0, SEED_K4};
			iter++;
			// words whose low 30 bits are zero are skipped
			if (x[29:0] != '0) begin
				if (kept == WORD_LO_IDX)
					word_lo = x[31:0];
				if (kept == WORD_HI_IDX)
					word_hi = x[31:0];
				kept++;
			end
		end
		s = {1'b0, word_hi[30:0], 2'b00, word_lo[29:0]};
		for (r = 0; r < WARMUP_ROUNDS; r++)
			s = next_mwc(s);
		return s;
	endfunction

	// seed whose lcg word at iteration n has zero low 30 bits, if one exists
	// x_n is affine in the seed, so solve a*seed = -b mod 2^30
	function automatic bit skip_seed(input int n, output logic [63:0] seed);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] rhs;
		logic [63:0] odd;
		logic [63:0] inv;
		int k;
		int i;
		a = {32'd0, SEED_K2};
		b = {32'd0, SEED_K1} * {32'd0, SEED_K2} + {32'd0, SEED_K3};
		for (i = 1; i <= n; i++) begin
			a = (a + 64'd1) * {32'd0, SEED_K3};
			b = b * {32'd0, SEED_K3} + {32'd0, SEED_K4};
		end
		rhs = (64'd0 - b) & MASK30;
		a = a & MASK30;
		seed = '0;
		k = 0;
		while (k < 30 && !a[k])
			k++;
		if (k == 30) begin
			if (rhs != '0)
				return 1'b0;
			seed = {$urandom, $urandom};
			return 1'b1;
		end
		if ((rhs & ((64'd1 << k) - 64'd1)) != '0)
			return 1'b0;
		// inverse of the odd part by newton iteration
		odd = a >> k;
		inv = odd;
		repeat (6) inv = inv * (64'd2 - odd * inv);
		seed = ((rhs >> k) * inv) & ((64'd1 << (30 - k)) - 64'd1);
		seed = seed + ({$urandom, $urandom} << (30 - k));
		return 1'b1;
	endfunction

	// random receiver stalls
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// predict each accepted request and check each accepted result
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				seed_reg = cfg_data;
				n_seed_writes++;
			end
			if (s_tvalid && s_tready) begin
				case (s_tdata[1:0])
					OP_DRAW: begin
						gen_state = next_mwc(gen_state);
						n_draw++;
					end
					OP_RESEED: begin
						gen_state = seeded_mwc(seed_reg);
						n_reseed++;
					end
					OP_LOAD: begin
						gen_state = s_tdata[65:2];
						n_load++;
					end
					default: begin
						n_report++;
					end
				endcase
				pending_states.push_back(gen_state);
			end
			if (m_tvalid && m_tready) begin
				if (pending_states.size() == 0) begin
					n_unexpected++;
					if (n_mismatch + n_unexpected <= 10)
						$display("unexpected result %h", m_tdata);
				end else begin
					want = pending_states.pop_front();
					n_checked++;
					if (m_tdata !== want) begin
						n_mismatch++;
						if (n_mismatch + n_unexpected <= 10)
							$display("result %0d: expected %h, got %h",
								n_checked, want, m_tdata);
					end
				end
			end
		end
	end

	// send one request, with random idle cycles before it
	task automatic send_request(input logic [OP_W-1:0] op, input logic [63:0] load);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, load, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// stop sending until every owed result has come back
	task automatic hold_requests();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_states.size() != 0)
			@(posedge clk);
	endtask

	// seed register write, only with the block idle
	task automatic write_seed(input logic [63:0] seed);
		hold_requests();
		cfg_valid <= 1'b1;
		cfg_data <= seed;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// zero state after reset, reseed from the reset seed
	task automatic test_zero_state();
		send_request(OP_REPORT, '0);
		send_request(OP_DRAW, '0);
		send_request(OP_DRAW, ~64'd0);
		send_request(OP_RESEED, '0);
	endtask

	// loads at the extremes, including carries beyond the multiplier
	task automatic test_load_extremes();
		send_request(OP_LOAD, '0);
		send_request(OP_DRAW, '0);
		send_request(OP_LOAD, ~64'd0);
		send_request(OP_DRAW, '0);
		send_request(OP_DRAW, '0);
		send_request(OP_LOAD, {32'hFFFF_FFFF, 32'd0});
		send_request(OP_DRAW, '0);
		send_request(OP_LOAD, {32'd0, 32'hFFFF_FFFF});
		send_request(OP_DRAW, '0);
		send_request(OP_REPORT, ~64'd0);
	endtask

	// reseed from the lowest and highest seed
	task automatic test_seed_extremes();
		write_seed('0);
		send_request(OP_RESEED, '0);
		send_request(OP_DRAW, '0);
		write_seed(~64'd0);
		send_request(OP_RESEED, ~64'd0);
		send_request(OP_DRAW, '0);
	endtask

	// seeds that make the word search skip a word
	task automatic test_word_skip();
		logic [63:0] seed;
		int found;
		int n;
		found = 0;
		for (n = 1; n <= 24 && found < 4; n++) begin
			if (skip_seed(n, seed)) begin
				write_seed(seed);
				send_request(OP_RESEED, seed);
				found++;
			end
		end
		send_request(OP_DRAW, '0);
	endtask

	// random mix of operations under one seed and one idling pattern
	task automatic run_random_phase(input int count, input int idle_pct,
			input int stall_pct, input bit pause_midway);
		logic [63:0] v;
		int r;
		int i;
		write_seed({$urandom, $urandom});
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				hold_requests();
			r = $urandom_range(99);
			v = {$urandom, $urandom};
			if (r < 65)
				send_request(OP_DRAW, v);
			else if (r < 80)
				send_request(OP_LOAD,
					($urandom_range(7) == 0) ? {32'hFFFF_FFFF, v[31:0]} : v);
			else if (r < 90)
				send_request(OP_RESEED, v);
			else
				send_request(OP_REPORT, v);
		end
	endtask

	// test sequence
	initial begin
		while (!arst_n)
			@(posedge clk);
		@(posedge clk);
		test_zero_state();
		test_load_extremes();
		test_seed_extremes();
		test_word_skip();
		run_random_phase(430, 0, 0, 1'b1);
		run_random_phase(430, 55, 0, 1'b0);
		run_random_phase(430, 0, 55, 1'b1);
		run_random_phase(430, 26, 26, 1'b0);
		hold_requests();
		repeat (20) @(posedge clk);
		$display("covered %0d draws, %0d reseeds, %0d loads, %0d state reports, %0d seed writes",
			n_draw, n_reseed, n_load, n_report, n_seed_writes);
		$display("checked %0d results: %0d wrong, %0d unexpected, %0d missing",
			n_checked, n_mismatch, n_unexpected, pending_states.size());
		if (n_mismatch == 0 && n_unexpected == 0 && pending_states.size() == 0)
			$display("[mwc32_generator_with_seeding] OK");
		else
			$display("[mwc32_generator_with_seeding] ERROR");
		$finish;
	end

endmodule
